>>> sv/pee_pkg.sv
// Package for the postfix evaluator: character codes, status codes, ALU opcodes and types.
`default_nettype none

package pee_pkg;

  // Data word width of the operand stack and the ALU
  localparam int DATA_W = 32;

  // ASCII character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_CARET = 8'h5E;  // '^'

  // Status / sticky error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_DIV0   = 2'd1;
  localparam logic [1:0] ERR_STACK  = 2'd2;
  localparam logic [1:0] ERR_SYMBOL = 2'd3;

  // ALU opcodes
  localparam int ALU_OP_W = 3;
  localparam logic [ALU_OP_W-1:0] ALU_ADD = 3'd0;
  localparam logic [ALU_OP_W-1:0] ALU_SUB = 3'd1;
  localparam logic [ALU_OP_W-1:0] ALU_MUL = 3'd2;
  localparam logic [ALU_OP_W-1:0] ALU_DIV = 3'd3;
  localparam logic [ALU_OP_W-1:0] ALU_MOD = 3'd4;
  localparam logic [ALU_OP_W-1:0] ALU_POW = 3'd5;

  // Sequencer to ALU request
  typedef struct packed {
    logic                start;
    logic [ALU_OP_W-1:0] op;
  } alu_req_t;

  // ALU to sequencer response
  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> sv/pee_ifs.sv
// Valid/ready channel interfaces for input characters and result words.
`default_nettype none

interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

>>> sv/pee_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/pee_alu.sv
// Shared iterative ALU: add, sub, combinational multiply, restoring divide, square-and-multiply power.
`default_nettype none

module pee_alu (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire pee_pkg::alu_req_t                req,
  input  wire logic [pee_pkg::DATA_W-1:0]       a,
  input  wire logic [pee_pkg::DATA_W-1:0]       b,
  output pee_pkg::alu_rsp_t                     rsp,
  output logic      [pee_pkg::DATA_W-1:0]       result
);

  localparam int W = pee_pkg::DATA_W;
  localparam int CNT_W = $clog2(W);

  localparam logic [2:0] A_IDLE   = 3'd0;
  localparam logic [2:0] A_DIV    = 3'd1;
  localparam logic [2:0] A_DIVFIX = 3'd2;
  localparam logic [2:0] A_POWM   = 3'd3;
  localparam logic [2:0] A_POWS   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic             done_r, done_nxt;
  logic             div0_r, div0_nxt;
  logic [W-1:0]     res_r, res_nxt;
  logic [W-1:0]     num_r, num_nxt;    // dividend shifting out, quotient shifting in
  logic [W-1:0]     den_r, den_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_q_r, neg_q_nxt;
  logic             neg_r_r, neg_r_nxt;
  logic             is_mod_r, is_mod_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     sq_r, sq_nxt;
  logic [W-1:0]     exp_r, exp_nxt;

  logic [W-1:0]     mul_x, mul_y, prod;
  logic [W-1:0]     a_mag, b_mag;
  logic [W:0]       rem_sh, diff;
  logic             ge;

  // The one multiplier, low word only
  assign prod = mul_x * mul_y;

  assign a_mag = a[W-1] ? (~a + 1'b1) : a;
  assign b_mag = b[W-1] ? (~b + 1'b1) : b;

  // Restoring divide step
  assign rem_sh = {rem_r, num_r[W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = ~diff[W];

  always_comb begin
    state_nxt  = state_r;
    done_nxt   = 1'b0;
    div0_nxt   = div0_r;
    res_nxt    = res_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    neg_q_nxt  = neg_q_r;
    neg_r_nxt  = neg_r_r;
    is_mod_nxt = is_mod_r;
    acc_nxt    = acc_r;
    sq_nxt     = sq_r;
    exp_nxt    = exp_r;
    mul_x      = a;
    mul_y      = b;

    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          div0_nxt = 1'b0;
          case (req.op)
            pee_pkg::ALU_ADD: begin
              res_nxt  = a + b;
              done_nxt = 1'b1;
            end
            pee_pkg::ALU_SUB: begin
              res_nxt  = a - b;
              done_nxt = 1'b1;
            end
            pee_pkg::ALU_MUL: begin
              res_nxt  = prod;
              done_nxt = 1'b1;
            end
            pee_pkg::ALU_DIV, pee_pkg::ALU_MOD: begin
              if (b == '0) begin
                res_nxt  = '0;
                div0_nxt = 1'b1;
                done_nxt = 1'b1;
              end else begin
                num_nxt    = a_mag;
                den_nxt    = b_mag;
                rem_nxt    = '0;
                cnt_nxt    = CNT_W'(W - 1);
                neg_q_nxt  = a[W-1] ^ b[W-1];
                neg_r_nxt  = a[W-1];
                is_mod_nxt = (req.op == pee_pkg::ALU_MOD);
                state_nxt  = A_DIV;
              end
            end
            pee_pkg::ALU_POW: begin
              if (b[W-1]) begin
                // negative exponent: only bases 1, -1 and 0 are special
                done_nxt = 1'b1;
                if (a == W'(1)) begin
                  res_nxt = W'(1);
                end else if (a == '1) begin
                  res_nxt = b[0] ? '1 : W'(1);
                end else if (a == '0) begin
                  res_nxt  = '0;
                  div0_nxt = 1'b1;
                end else begin
                  res_nxt = '0;
                end
              end else begin
                acc_nxt   = W'(1);
                sq_nxt    = a;
                exp_nxt   = b;
                state_nxt = A_POWM;
              end
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end

      // one quotient bit per cycle
      A_DIV: begin
        rem_nxt = ge ? diff[W-1:0] : rem_sh[W-1:0];
        num_nxt = {num_r[W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = A_DIVFIX;
        end
      end

      // apply signs: quotient toward zero, remainder takes dividend sign
      A_DIVFIX: begin
        if (is_mod_r) begin
          res_nxt = neg_r_r ? (~rem_r + 1'b1) : rem_r;
        end else begin
          res_nxt = neg_q_r ? (~num_r + 1'b1) : num_r;
        end
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end

      // acc *= sq when the exponent bit is set
      A_POWM: begin
        mul_x = acc_r;
        mul_y = sq_r;
        if (exp_r == '0) begin
          res_nxt   = acc_r;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end else begin
          if (exp_r[0]) begin
            acc_nxt = prod;
          end
          state_nxt = A_POWS;
        end
      end

      // sq *= sq, next exponent bit
      A_POWS: begin
        mul_x     = sq_r;
        mul_y     = sq_r;
        sq_nxt    = prod;
        exp_nxt   = {1'b0, exp_r[W-1:1]};
        state_nxt = A_POWM;
      end

      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    div0_r   <= div0_nxt;
    res_r    <= res_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    neg_q_r  <= neg_q_nxt;
    neg_r_r  <= neg_r_nxt;
    is_mod_r <= is_mod_nxt;
    acc_r    <= acc_nxt;
    sq_r     <= sq_nxt;
    exp_r    <= exp_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.div0 = div0_r;
  assign result   = res_r;

endmodule

`default_nettype wire

>>> sv/postfix_expression_evaluator_top.sv
// Postfix expression evaluator: operand stack in RAM, sequencer, shared iterative ALU.
//
// Usage: characters of a postfix expression enter on in_ch (symbol, last), one
// word per valid/ready handshake. Digits push, operators pop two and push one.
// The word with last set produces one result word on out_ch (value, status):
// the stack top, or 0 with a nonzero status after a divide by zero, stack
// under/overflow or unknown symbol. Afterwards the stack and error are cleared.
// Steps per input word (in_ch.ready is low while a word is being worked on):
//   digit, unknown symbol or operator on a short stack: handled in S_IDLE alone
//   + - *: one stack RAM read (S_READ), then one ALU pass (S_EXEC)
//   / %: restoring divider, one quotient bit per cycle; no divide steps on a zero divisor
//   ^: a multiply and a square step per significant exponent bit (one shared multiplier);
//      no multiply steps for a negative exponent
//   a word with last set: then S_FIN loads the output register.
// The output register frees in_ch from out_ch: the next expression is taken
// while a result waits; only the next result's final cycle waits on out_ready.
// Reset (synchronous, rst_n low) empties the stack and clears the error; the
// stack RAM itself is not cleared and needs no sweep.
`default_nettype none

module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pee_in_if.sink    in_ch,
  pee_out_if.source out_ch
);

  localparam int W      = pee_pkg::DATA_W;
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int PTR_W  = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [PTR_W-1:0]                sp_r, sp_nxt;
  logic [1:0]                      err_r, err_nxt;
  logic [W-1:0]                    top_r, top_nxt;
  logic                            last_r, last_nxt;
  logic [pee_pkg::ALU_OP_W-1:0]    op_r, op_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [W-1:0]                    out_value_r, out_value_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;

  logic                            accept;
  logic                            is_digit, is_known;
  logic [7:0]                      digit_val;
  logic [pee_pkg::ALU_OP_W-1:0]    sym_op;
  logic [PTR_W-1:0]                sp_m2;
  logic                            we;
  logic [ADDR_W-1:0]               waddr, raddr;
  logic [W-1:0]                    wdata, rdata;
  logic [1:0]                      fin_status;
  pee_pkg::alu_req_t               alu_req;
  pee_pkg::alu_rsp_t               alu_rsp;
  logic [W-1:0]                    alu_res;

  // keep the first error of an expression
  function automatic logic [1:0] sticky(input logic [1:0] cur, input logic [1:0] code);
    sticky = (cur == pee_pkg::ERR_NONE) ? code : cur;
  endfunction

  assign accept    = in_ch.valid && in_ch.ready;
  assign digit_val = in_ch.symbol - pee_pkg::CH_ZERO;
  assign sp_m2     = sp_r - PTR_W'(2);
  assign raddr     = sp_m2[ADDR_W-1:0];

  // symbol decode
  always_comb begin
    is_digit = in_ch.symbol inside {[pee_pkg::CH_ZERO:pee_pkg::CH_NINE]};
    is_known = 1'b1;
    sym_op   = pee_pkg::ALU_ADD;
    case (in_ch.symbol)
      pee_pkg::CH_PLUS:  sym_op = pee_pkg::ALU_ADD;
      pee_pkg::CH_MINUS: sym_op = pee_pkg::ALU_SUB;
      pee_pkg::CH_STAR:  sym_op = pee_pkg::ALU_MUL;
      pee_pkg::CH_SLASH: sym_op = pee_pkg::ALU_DIV;
      pee_pkg::CH_PCT:   sym_op = pee_pkg::ALU_MOD;
      pee_pkg::CH_CARET: sym_op = pee_pkg::ALU_POW;
      default:           is_known = 1'b0;
    endcase
  end

  // final status: an empty stack at the end is a stack error
  assign fin_status = (sp_r == '0) ? sticky(err_r, pee_pkg::ERR_STACK) : err_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    last_nxt       = last_r;
    op_nxt         = op_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    we             = 1'b0;
    waddr          = sp_r[ADDR_W-1:0];
    wdata          = '0;
    alu_req.start  = 1'b0;
    alu_req.op     = op_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt  = in_ch.last;
          state_nxt = in_ch.last ? S_FIN : S_IDLE;
          if (is_digit) begin
            if (sp_r == PTR_W'(STACK_DEPTH)) begin
              err_nxt = sticky(err_r, pee_pkg::ERR_STACK);
            end else begin
              we      = 1'b1;
              wdata   = {{(W - 8){1'b0}}, digit_val};
              top_nxt = wdata;
              sp_nxt  = sp_r + 1'b1;
            end
          end else if (sp_r < PTR_W'(2)) begin
            // short stack: consume what is there, push 0
            err_nxt = sticky(err_r, pee_pkg::ERR_STACK);
            we      = 1'b1;
            waddr   = '0;
            top_nxt = '0;
            sp_nxt  = PTR_W'(1);
          end else if (!is_known) begin
            err_nxt = sticky(err_r, pee_pkg::ERR_SYMBOL);
            we      = 1'b1;
            waddr   = sp_m2[ADDR_W-1:0];
            top_nxt = '0;
            sp_nxt  = sp_r - 1'b1;
          end else begin
            // left operand read from RAM, right operand is the cached top
            op_nxt    = sym_op;
            sp_nxt    = sp_m2;
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        alu_req.start = 1'b1;
        state_nxt     = S_EXEC;
      end

      S_EXEC: begin
        if (alu_rsp.done) begin
          we      = 1'b1;
          wdata   = alu_res;
          top_nxt = alu_res;
          sp_nxt  = sp_r + 1'b1;
          if (alu_rsp.div0) begin
            err_nxt = sticky(err_r, pee_pkg::ERR_DIV0);
          end
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status;
          out_value_nxt  = (fin_status == pee_pkg::ERR_NONE) ? top_r : '0;
          sp_nxt         = '0;
          err_nxt        = pee_pkg::ERR_NONE;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      err_r       <= pee_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    last_r       <= last_nxt;
    op_r         <= op_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // operand stack
  pee_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pee_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (rdata),
    .b      (top_r),
    .rsp    (alu_rsp),
    .result (alu_res)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

endmodule

`default_nettype wire
